>>> rtl/svpg_pkg.sv
`default_nettype none

package svpg_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int CFG_FRAME_W   = 20;
    localparam int MODE_W        = 2;
    localparam int CHAN_W        = 2;
    localparam int ACTION_W      = 2;
    localparam int RATE_W        = 24;
    localparam int INDEX_W       = 20;
    localparam int ADDR_OUT_W    = 21;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 5;
    localparam int REG_IDX_W     = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_FRAME   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_START   = 2'd2
    } t_action;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOOP    = 2'd0,
        MODE_SUSTAIN = 2'd1,
        MODE_ONESHOT = 2'd2
    } t_play_mode;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LOOP_START  = 3'd0,
        REG_LOOP_END    = 3'd1,
        REG_WAVE_LENGTH = 3'd2,
        REG_PLAY_MODE   = 3'd3,
        REG_BOUNCE_LOOP = 3'd4,
        REG_CHANNELS    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_FRAME_W-1:0] loop_start_frame;
        logic [CFG_FRAME_W-1:0] loop_end_frame;
        logic [CFG_FRAME_W-1:0] wave_length;
        logic [MODE_W-1:0]      play_mode;
        logic                   bounce_loop;
        logic [CHAN_W-1:0]      channel_count;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        loop_start_frame: '0,
        loop_end_frame:   '0,
        wave_length:      '0,
        play_mode:        '0,
        bounce_loop:      1'b0,
        channel_count:    CHAN_W'(1)
    };

    typedef struct packed {
        logic                  frame_valid;
        logic [INDEX_W-1:0]    frame_index;
        logic [ADDR_OUT_W-1:0] left_address;
        logic [ADDR_OUT_W-1:0] right_address;
        logic                  still_playing;
        logic                  reversed;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/svpg_if.sv
`default_nettype none

interface svpg_in_if;
    logic                             valid;
    logic                             ready;
    logic [svpg_pkg::ACTION_W-1:0]    action;
    logic [svpg_pkg::RATE_W-1:0]      step_rate;

    modport source (output valid, action, step_rate, input ready);
    modport sink   (input valid, action, step_rate, output ready);
endinterface

interface svpg_out_if;
    logic                             valid;
    logic                             ready;
    logic                             frame_valid;
    logic [svpg_pkg::INDEX_W-1:0]     frame_index;
    logic [svpg_pkg::ADDR_OUT_W-1:0]  left_address;
    logic [svpg_pkg::ADDR_OUT_W-1:0]  right_address;
    logic                             still_playing;
    logic                             reversed;

    modport source (output valid, frame_valid, frame_index, left_address, right_address,
                    still_playing, reversed, input ready);
    modport sink   (input valid, frame_valid, frame_index, left_address, right_address,
                    still_playing, reversed, output ready);
endinterface

`default_nettype wire

>>> rtl/svpg_regs.sv
`default_nettype none

module svpg_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [svpg_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [svpg_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [svpg_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    output svpg_pkg::t_cfg                           o_cfg
);

    svpg_pkg::t_cfg       r_cfg;
    svpg_pkg::t_reg_idx   w_idx;
    logic                 w_wr;

    assign w_idx  = svpg_pkg::t_reg_idx'(paddr[svpg_pkg::APB_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= svpg_pkg::CFG_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                svpg_pkg::REG_LOOP_START: begin
                    r_cfg.loop_start_frame <= pwdata[svpg_pkg::CFG_FRAME_W-1:0];
                end
                svpg_pkg::REG_LOOP_END: begin
                    r_cfg.loop_end_frame <= pwdata[svpg_pkg::CFG_FRAME_W-1:0];
                end
                svpg_pkg::REG_WAVE_LENGTH: begin
                    r_cfg.wave_length <= pwdata[svpg_pkg::CFG_FRAME_W-1:0];
                end
                svpg_pkg::REG_PLAY_MODE: begin
                    r_cfg.play_mode <= pwdata[svpg_pkg::MODE_W-1:0];
                end
                svpg_pkg::REG_BOUNCE_LOOP: begin
                    r_cfg.bounce_loop <= pwdata[0];
                end
                svpg_pkg::REG_CHANNELS: begin
                    r_cfg.channel_count <= pwdata[svpg_pkg::CHAN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            svpg_pkg::REG_LOOP_START:  prdata = svpg_pkg::APB_DATA_W'(r_cfg.loop_start_frame);
            svpg_pkg::REG_LOOP_END:    prdata = svpg_pkg::APB_DATA_W'(r_cfg.loop_end_frame);
            svpg_pkg::REG_WAVE_LENGTH: prdata = svpg_pkg::APB_DATA_W'(r_cfg.wave_length);
            svpg_pkg::REG_PLAY_MODE:   prdata = svpg_pkg::APB_DATA_W'(r_cfg.play_mode);
            svpg_pkg::REG_BOUNCE_LOOP: prdata = svpg_pkg::APB_DATA_W'(r_cfg.bounce_loop);
            svpg_pkg::REG_CHANNELS:    prdata = svpg_pkg::APB_DATA_W'(r_cfg.channel_count);
            default:                   prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/svpg_step.sv
`default_nettype none

module svpg_step #(
    parameter int FRAME_BITS = 20,
    localparam int POS_BITS  = FRAME_BITS + svpg_pkg::FRACTION_BITS + 2
) (
    input  wire logic [svpg_pkg::ACTION_W-1:0]   i_action,
    input  wire logic [svpg_pkg::RATE_W-1:0]     i_rate,
    input  wire svpg_pkg::t_cfg                  i_cfg,
    input  wire logic [POS_BITS-1:0]             i_pos,
    input  wire logic                            i_back,
    input  wire logic                            i_held,
    input  wire logic                            i_active,
    output logic      [POS_BITS-1:0]             o_pos,
    output logic                                 o_back,
    output logic                                 o_held,
    output logic                                 o_active,
    output svpg_pkg::t_result                    o_res
);

    // bounds are frame << 16, so they need CFG_FRAME_W + 16 bits plus sign and headroom
    localparam int LIM_W = svpg_pkg::CFG_FRAME_W + svpg_pkg::FRACTION_BITS + 1;
    localparam int CW    = ((POS_BITS > LIM_W) ? POS_BITS : LIM_W) + 2;
    localparam logic [svpg_pkg::FRACTION_BITS-1:0] FRAC_ZERO = '0;

    logic signed [CW-1:0] w_pos, w_rate, w_start, w_end, w_wend, w_limit;
    logic signed [CW-1:0] w_back_pos, w_fwd_pos, w_stepped, w_wrapped;
    logic                 w_wrap_mode, w_over, w_wrap, w_stop, w_inside;
    logic [FRAME_BITS-1:0]             w_idx;
    logic [svpg_pkg::INDEX_W-1:0]      w_index;
    logic [svpg_pkg::ADDR_OUT_W-1:0]   w_left, w_right;

    assign w_pos   = $signed({{(CW-POS_BITS){i_pos[POS_BITS-1]}}, i_pos});
    assign w_rate  = $signed(CW'(i_rate));
    assign w_start = $signed(CW'({i_cfg.loop_start_frame, FRAC_ZERO}));
    assign w_end   = $signed(CW'({i_cfg.loop_end_frame, FRAC_ZERO}));
    assign w_wend  = $signed(CW'({i_cfg.wave_length, FRAC_ZERO}));

    assign w_back_pos = w_pos - w_rate;
    assign w_fwd_pos  = w_pos + w_rate;

    // loop mode and held sustain wrap at loop end; one-shot stops there;
    // released sustain (and the unused mode) plays to wave end
    assign w_wrap_mode = (i_cfg.play_mode == svpg_pkg::MODE_LOOP)
                      || ((i_cfg.play_mode == svpg_pkg::MODE_SUSTAIN) && i_held);
    assign w_limit = (w_wrap_mode || (i_cfg.play_mode == svpg_pkg::MODE_ONESHOT))
                   ? w_end : w_wend;
    assign w_over  = w_fwd_pos > w_limit;

    always_comb begin
        if (i_back) begin
            w_wrap   = w_back_pos < w_start;
            w_stop   = 1'b0;
            w_inside = w_pos > (w_wrap ? w_start : w_back_pos);
        end else begin
            w_wrap   = w_over && w_wrap_mode;
            w_stop   = w_over && !w_wrap_mode;
            w_inside = w_pos < (w_over ? w_limit : w_fwd_pos);
        end
    end

    assign w_stepped = i_back ? w_back_pos : w_fwd_pos;
    assign w_wrapped = i_cfg.bounce_loop
                     ? (((i_back ? w_start : w_end) <<< 1) - w_stepped)
                     : (w_stepped - (w_end - w_start));

    assign w_idx   = i_pos[svpg_pkg::FRACTION_BITS +: FRAME_BITS];
    assign w_index = svpg_pkg::INDEX_W'(w_idx);
    assign w_left  = i_cfg.channel_count[1] ? {w_index, 1'b0} : {1'b0, w_index};
    assign w_right = i_cfg.channel_count[1] ? (w_left + svpg_pkg::ADDR_OUT_W'(1)) : w_left;

    always_comb begin
        o_pos    = i_pos;
        o_back   = i_back;
        o_held   = i_held;
        o_active = i_active;
        o_res    = '0;
        unique case (svpg_pkg::t_action'(i_action))
            svpg_pkg::ACT_START: begin
                o_active = 1'b1;
                o_held   = 1'b1;
                o_back   = 1'b0;
                o_pos    = (i_cfg.play_mode == svpg_pkg::MODE_ONESHOT)
                         ? POS_BITS'(w_start) : '0;
            end
            svpg_pkg::ACT_RELEASE: begin
                o_held = 1'b0;
            end
            svpg_pkg::ACT_FRAME: begin
                if (i_active) begin
                    // negative position is never inside
                    if (!w_inside || w_pos[CW-1]) begin
                        o_active = 1'b0;
                    end else begin
                        o_res.frame_valid   = 1'b1;
                        o_res.frame_index   = w_index;
                        o_res.left_address  = w_left;
                        o_res.right_address = w_right;
                        o_pos = POS_BITS'(w_wrap ? w_wrapped : w_stepped);
                        if (w_stop) begin
                            o_active = 1'b0;
                        end
                        if (w_wrap && i_cfg.bounce_loop) begin
                            o_back = !i_back;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        o_res.still_playing = o_active;
        o_res.reversed      = o_back;
    end

endmodule

`default_nettype wire

>>> rtl/sample_voice_position_generator.sv
// Sample voice position generator: one voice of a wavetable player.
// Input channel i_in carries an action (frame, release, start) and an
// unsigned 8.16 step rate; each transfer gives exactly one transfer on
// o_out with the frame index, left/right wave memory addresses and the
// voice flags. Loop bounds, play mode, bounce loop and channel count are
// written over the APB port; write them only while the voice is idle,
// which the block itself does not enforce. Each item is held in the
// input register, then the position update (one add, one compare
// against the selected bound, one wrap subtract) is computed combinationally
// into the output register, from which o_out offers the result.
// One item per cycle sustained while o_out is ready; the position register
// is updated as each result is registered, so the next item sees it.
// If o_out stalls, the held result waits in the output register and one
// more item is taken into the input register; i_in.ready then drops until
// the receiver takes the result.
// Reset (synchronous, active low) empties both registers, stops the voice,
// zeroes the position and sets the configuration to its defaults.
`default_nettype none

module sample_voice_position_generator #(
    parameter int FRAME_BITS = 20
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    svpg_in_if.sink                                i_in,
    svpg_out_if.source                             o_out,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [svpg_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [svpg_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [svpg_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    localparam int POS_BITS = FRAME_BITS + svpg_pkg::FRACTION_BITS + 2;

    svpg_pkg::t_cfg                  w_cfg;

    logic                            r_in_valid;
    logic [svpg_pkg::ACTION_W-1:0]   r_action;
    logic [svpg_pkg::RATE_W-1:0]     r_rate;

    logic [POS_BITS-1:0]             r_pos, n_pos;
    logic                            r_back, n_back;
    logic                            r_held, n_held;
    logic                            r_active, n_active;

    logic                            r_out_valid;
    svpg_pkg::t_result               r_out, n_out;

    logic                            w_advance;

    svpg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    svpg_step #(
        .FRAME_BITS (FRAME_BITS)
    ) u_step (
        .i_action (r_action),
        .i_rate   (r_rate),
        .i_cfg    (w_cfg),
        .i_pos    (r_pos),
        .i_back   (r_back),
        .i_held   (r_held),
        .i_active (r_active),
        .o_pos    (n_pos),
        .o_back   (n_back),
        .o_held   (n_held),
        .o_active (n_active),
        .o_res    (n_out)
    );

    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_action <= i_in.action;
            r_rate   <= i_in.step_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_back   <= 1'b0;
            r_held   <= 1'b1;
            r_active <= 1'b0;
        end else if (w_advance) begin
            r_pos    <= n_pos;
            r_back   <= n_back;
            r_held   <= n_held;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.frame_valid   = r_out.frame_valid;
    assign o_out.frame_index   = r_out.frame_index;
    assign o_out.left_address  = r_out.left_address;
    assign o_out.right_address = r_out.right_address;
    assign o_out.still_playing = r_out.still_playing;
    assign o_out.reversed      = r_out.reversed;

    // a processed item always lands in the output register
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("processed item did not reach the output register");

    // right address is the left address or the one after it
    a_addr_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_valid)
        |-> ((svpg_pkg::ADDR_OUT_W'(r_out.right_address - r_out.left_address) == '0)
          || (svpg_pkg::ADDR_OUT_W'(r_out.right_address - r_out.left_address)
              == svpg_pkg::ADDR_OUT_W'(1))))
        else $error("left/right address pair inconsistent");

    // an empty input register never blocks the sender
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_in.ready)
        else $error("input blocked while input register empty");

    // the voice state moves only when an item is processed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> ($stable(r_pos) && $stable(r_active) && $stable(r_back)))
        else $error("voice state changed without an item");

endmodule

`default_nettype wire
